/* src/ufc_pkg.sv */
// Shared types and codes for the UART flow-control front end.
// No dependencies; every other file refers to this package by scoped names.
package ufc_pkg;

    // Field widths fixed by the interface
    localparam int unsigned ACT_W  = 3;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned STS_W  = 3;
    localparam int unsigned MARK_W = 6;
    localparam int unsigned FILL_W = 6;
    localparam int unsigned CIDX_W = 1;

    // Action codes of an input word
    localparam logic [ACT_W-1:0] ACT_RX_BYTE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_TAKE_RX    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SEND_REQ   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RESET_DONE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RTS_FELL   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_TX_EMPTY   = 3'd5;

    // Sender states
    localparam logic [2:0] SND_IDLE       = 3'd0;
    localparam logic [2:0] SND_SENT       = 3'd1;
    localparam logic [2:0] SND_HOLD_RESET = 3'd2;
    localparam logic [2:0] SND_HOLD_RTS   = 3'd3;
    localparam logic [2:0] SND_HOLD_BUSY  = 3'd4;

    // Send attempt outcome
    localparam logic [STS_W-1:0] STS_OK         = 3'd0;
    localparam logic [STS_W-1:0] STS_HOLD_RESET = 3'd1;
    localparam logic [STS_W-1:0] STS_HOLD_RTS   = 3'd2;
    localparam logic [STS_W-1:0] STS_HOLD_BUSY  = 3'd3;
    localparam logic [STS_W-1:0] STS_REFUSED    = 3'd4;

    // Configuration register indexes and reset values
    localparam logic [CIDX_W-1:0] CFG_HIGH_FREE = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_LOW_FILL  = 1'd1;
    localparam logic [MARK_W-1:0] HIGH_FREE_RST = 6'd5;
    localparam logic [MARK_W-1:0] LOW_FILL_RST  = 6'd16;

    // Result of one item, minus the byte read from the receive store
    typedef struct packed {
        logic              rx_take;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_data;
        logic              tx_done;
        logic [STS_W-1:0]  send_status;
        logic              cts;
        logic              reset_released;
        logic              overflow;
        logic [FILL_W-1:0] fill_level;
    } t_res;

endpackage

/* src/uart_flow_control_front_end_top.sv */
// UART RTS/CTS flow-control front end: receive FIFO with CTS hysteresis, one-byte sender.
// Top level; depends on ufc_pkg, ufc_ctrl and ufc_rx_mem.
//
// Each input word carries one action: push a received byte, take a byte from the receive
// FIFO, request a send, or report a link event (partner reset done, RTS fell, transmit
// register empty). Every accepted word yields exactly one result word with the byte taken
// (if any), the byte loaded into the transmitter (if any), the send outcome, and the CTS,
// partner-reset, overflow and fill levels after the action. The block takes one word per
// cycle while o_in_stall is low; a result passes through stage 1 and then the output
// register, because the receive store is a synchronous memory with a registered read that
// sits between the control update and the output register. Control state (pointers, count,
// CTS, sender state) is updated in the accept cycle, so back-to-back words never see stale
// state; a byte pushed in one cycle can be taken in the next. A push into a full FIFO is
// dropped and flagged as overflow; a send request while the sender is busy is refused and
// leaves it unchanged. Write the two marks only while no word is in flight.
module uart_flow_control_front_end_top #(
    parameter int unsigned FIFO_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input word channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ufc_pkg::ACT_W-1:0]      i_action,
    input  logic [ufc_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                           i_rts_high,
    input  logic                           i_tx_reg_empty,
    // result word channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_rx_valid,
    output logic [ufc_pkg::BYTE_W-1:0]     o_rx_data,
    output logic                           o_tx_valid,
    output logic [ufc_pkg::BYTE_W-1:0]     o_tx_data,
    output logic                           o_tx_done,
    output logic [ufc_pkg::STS_W-1:0]      o_send_status,
    output logic                           o_cts_out,
    output logic                           o_reset_released,
    output logic                           o_overflow,
    output logic [ufc_pkg::FILL_W-1:0]     o_fill_level,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [ufc_pkg::CIDX_W-1:0]     i_cfg_idx,
    input  logic [ufc_pkg::MARK_W-1:0]     i_cfg_data
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

    logic                       acc;
    logic                       out_adv;
    logic                       mem_we;
    logic                       mem_re;
    logic [PTR_W-1:0]           mem_waddr;
    logic [PTR_W-1:0]           mem_raddr;
    logic [ufc_pkg::BYTE_W-1:0] mem_rdata;
    ufc_pkg::t_res              step_res;

    // stage 1: control result waiting for the memory read
    logic                       r_s1_vld;
    ufc_pkg::t_res              r_s1;
    // output register
    logic                       r_out_vld;
    ufc_pkg::t_res              r_out;
    logic [ufc_pkg::BYTE_W-1:0] r_out_rx_data;

    // output register frees up when empty or taken this cycle
    assign out_adv    = !r_out_vld || !i_out_stall;
    // hold input only when stage 1 is full and cannot drain
    assign o_in_stall = r_s1_vld && !out_adv;
    assign acc        = i_in_valid && !o_in_stall;

    ufc_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_acc          (acc),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .i_rts_high     (i_rts_high),
        .i_tx_reg_empty (i_tx_reg_empty),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .o_res          (step_res)
    );

    ufc_rx_mem #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_data_byte),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // advance stage 1 on accept, drop it once it moves out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (acc) begin
            r_s1_vld <= 1'b1;
        end else if (out_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= step_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    // merge the read byte in; zero when no byte was taken
    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_vld) begin
            r_out         <= r_s1;
            r_out_rx_data <= r_s1.rx_take ? mem_rdata : '0;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_rx_valid       = r_out.rx_take;
    assign o_rx_data        = r_out_rx_data;
    assign o_tx_valid       = r_out.tx_valid;
    assign o_tx_data        = r_out.tx_data;
    assign o_tx_done        = r_out.tx_done;
    assign o_send_status    = r_out.send_status;
    assign o_cts_out        = r_out.cts;
    assign o_reset_released = r_out.reset_released;
    assign o_overflow       = r_out.overflow;
    assign o_fill_level     = r_out.fill_level;

    // an accepted word always lands in stage 1
    a_acc_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_s1_vld)
        else $error("accepted word lost before stage 1");

    // a byte can only be loaded once the partner reset is released
    a_tx_needs_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tx_valid) |-> o_reset_released)
        else $error("byte sent while partner held in reset");

    // one action per word: a take never overflows nor loads the sender
    a_take_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rx_valid) |-> (!o_overflow && !o_tx_valid && !o_tx_done))
        else $error("take word reports another action");

    // completion and a new load never share a word; a load reports a clean status
    a_tx_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tx_valid) |-> (!o_tx_done && o_send_status == ufc_pkg::STS_OK))
        else $error("inconsistent send result");

endmodule

/* src/ufc_rx_mem.sv */
// Receive byte store: one write port, one registered read port.
// Depends on ufc_pkg for the byte width.
module ufc_rx_mem #(
    parameter int unsigned FIFO_DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(FIFO_DEPTH)-1:0]    i_waddr,
    input  logic [ufc_pkg::BYTE_W-1:0]       i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(FIFO_DEPTH)-1:0]    i_raddr,
    output logic [ufc_pkg::BYTE_W-1:0]       o_rdata
);

    logic [ufc_pkg::BYTE_W-1:0] r_mem [FIFO_DEPTH];
    logic [ufc_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/ufc_ctrl.sv */
// Control state: FIFO pointers and count, CTS, partner reset flag, sender.
// Depends on ufc_pkg; drives the ports of ufc_rx_mem.
module ufc_ctrl #(
    parameter int unsigned FIFO_DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_acc,
    input  logic [ufc_pkg::ACT_W-1:0]        i_action,
    input  logic [ufc_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                             i_rts_high,
    input  logic                             i_tx_reg_empty,
    input  logic                             i_cfg_we,
    input  logic [ufc_pkg::CIDX_W-1:0]       i_cfg_idx,
    input  logic [ufc_pkg::MARK_W-1:0]       i_cfg_data,
    output logic                             o_mem_we,
    output logic [$clog2(FIFO_DEPTH)-1:0]    o_mem_waddr,
    output logic                             o_mem_re,
    output logic [$clog2(FIFO_DEPTH)-1:0]    o_mem_raddr,
    output ufc_pkg::t_res                    o_res
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned CMP_W = CNT_W + ufc_pkg::MARK_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
    localparam logic [CMP_W-1:0] CMP_FULL = CMP_W'(FIFO_DEPTH);

    logic [PTR_W-1:0]           r_wptr, n_wptr;
    logic [PTR_W-1:0]           r_rptr, n_rptr;
    logic [CNT_W-1:0]           r_count, n_count;
    logic                       r_cts, n_cts;
    logic                       r_rst_done, n_rst_done;
    logic [2:0]                 r_snd, n_snd;
    logic [ufc_pkg::BYTE_W-1:0] r_held, n_held;
    logic [ufc_pkg::MARK_W-1:0] r_high_free;
    logic [ufc_pkg::MARK_W-1:0] r_low_fill;

    logic                       push_ok;
    logic                       take_ok;
    logic                       try_en;
    logic [CMP_W-1:0]           cnt_ext;
    logic [CMP_W-1:0]           free_ext;

    always_comb begin
        n_wptr     = r_wptr;
        n_rptr     = r_rptr;
        n_count    = r_count;
        n_cts      = r_cts;
        n_rst_done = r_rst_done;
        n_snd      = r_snd;
        n_held     = r_held;
        push_ok    = 1'b0;
        take_ok    = 1'b0;
        try_en     = 1'b0;
        o_res      = '0;

        unique case (i_action)
            ufc_pkg::ACT_RX_BYTE: begin
                if (r_count != CNT_FULL) begin
                    push_ok = 1'b1;
                    n_wptr  = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
                    n_count = r_count + 1'b1;
                end else begin
                    o_res.overflow = 1'b1;
                end
            end
            ufc_pkg::ACT_TAKE_RX: begin
                if (r_count != '0) begin
                    take_ok       = 1'b1;
                    o_res.rx_take = 1'b1;
                    n_rptr        = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
                    n_count       = r_count - 1'b1;
                end
            end
            ufc_pkg::ACT_SEND_REQ: begin
                if (r_snd != ufc_pkg::SND_IDLE) begin
                    o_res.send_status = ufc_pkg::STS_REFUSED;
                end else begin
                    n_held = i_data_byte;
                    try_en = 1'b1;
                end
            end
            ufc_pkg::ACT_RESET_DONE: begin
                n_rst_done = 1'b1;
                try_en     = (r_snd == ufc_pkg::SND_HOLD_RESET);
            end
            ufc_pkg::ACT_RTS_FELL: begin
                try_en = (r_snd == ufc_pkg::SND_HOLD_RTS);
            end
            ufc_pkg::ACT_TX_EMPTY: begin
                if (r_snd == ufc_pkg::SND_SENT) begin
                    n_snd         = ufc_pkg::SND_IDLE;
                    o_res.tx_done = 1'b1;
                end else begin
                    try_en = (r_snd == ufc_pkg::SND_HOLD_BUSY);
                end
            end
            default: begin
            end
        endcase

        // send attempt: reset released, then RTS low, then register empty
        if (try_en) begin
            if (!n_rst_done) begin
                n_snd             = ufc_pkg::SND_HOLD_RESET;
                o_res.send_status = ufc_pkg::STS_HOLD_RESET;
            end else if (i_rts_high) begin
                n_snd             = ufc_pkg::SND_HOLD_RTS;
                o_res.send_status = ufc_pkg::STS_HOLD_RTS;
            end else if (!i_tx_reg_empty) begin
                n_snd             = ufc_pkg::SND_HOLD_BUSY;
                o_res.send_status = ufc_pkg::STS_HOLD_BUSY;
            end else begin
                n_snd          = ufc_pkg::SND_SENT;
                o_res.tx_valid = 1'b1;
                o_res.tx_data  = n_held;
            end
        end

        // CTS hysteresis on the updated fill level
        cnt_ext  = CMP_W'(n_count);
        free_ext = CMP_FULL - cnt_ext;
        if ((i_action == ufc_pkg::ACT_RX_BYTE) && !r_cts
                && (free_ext < CMP_W'(r_high_free))) begin
            n_cts = 1'b1;
        end
        if (take_ok && r_cts && (cnt_ext < CMP_W'(r_low_fill))) begin
            n_cts = 1'b0;
        end

        o_res.cts            = n_cts;
        o_res.reset_released = n_rst_done;
        o_res.fill_level     = cnt_ext[ufc_pkg::FILL_W-1:0];
    end

    assign o_mem_we    = i_acc && push_ok;
    assign o_mem_waddr = r_wptr;
    assign o_mem_re    = i_acc && take_ok;
    assign o_mem_raddr = r_rptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_count    <= '0;
            r_cts      <= 1'b0;
            r_rst_done <= 1'b0;
            r_snd      <= ufc_pkg::SND_IDLE;
            r_held     <= '0;
        end else if (i_acc) begin
            r_wptr     <= n_wptr;
            r_rptr     <= n_rptr;
            r_count    <= n_count;
            r_cts      <= n_cts;
            r_rst_done <= n_rst_done;
            r_snd      <= n_snd;
            r_held     <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_free <= ufc_pkg::HIGH_FREE_RST;
            r_low_fill  <= ufc_pkg::LOW_FILL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ufc_pkg::CFG_HIGH_FREE: r_high_free <= i_cfg_data;
                ufc_pkg::CFG_LOW_FILL:  r_low_fill  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule
